// File: src/ppd_pkg.sv
// Shared types, opcode table and constants for the PowerPC instruction decoder.
`timescale 1ns / 1ps

package ppd_pkg;

	localparam int NUM_ROWS    = 80;
	localparam int GROUP_SIZE  = 8;
	localparam int NUM_GROUPS  = NUM_ROWS / GROUP_SIZE;
	localparam int IDX_W       = 7;
	localparam int LOCAL_W     = $clog2(GROUP_SIZE);
	localparam int GROUP_W     = $clog2(NUM_GROUPS);

	// Row kinds, which select the operand format and the flags.
	typedef enum logic [2:0] {
		K_OTHER = 3'd0,
		K_BREL  = 3'd1,
		K_BABS  = 3'd2,
		K_BCOND = 3'd3,
		K_BIND  = 3'd4,
		K_LOAD  = 3'd5,
		K_STORE = 3'd6
	} kind_t;

	typedef struct packed {
		logic [31:0] value;
		logic [31:0] mask;
		kind_t       kind;
	} row_t;

	// Handshake control handed to each pipeline stage.
	typedef struct packed {
		logic valid;   // upstream stage holds a word
		logic load;    // this stage takes a new word this cycle
	} stage_ctl_t;

	// Opcode table; the lowest matching row wins.
	localparam row_t ROWS [NUM_ROWS] = '{
		'{32'h7C000214, 32'hFC0007FE, K_OTHER}, '{32'h7C000215, 32'hFC0007FF, K_OTHER},
		'{32'h38000000, 32'hFC000000, K_OTHER}, '{32'h3C000000, 32'hFC000000, K_OTHER},
		'{32'h30000000, 32'hFC000000, K_OTHER}, '{32'h34000000, 32'hFC000000, K_OTHER},
		'{32'h7C000038, 32'hFC0007FE, K_OTHER}, '{32'h7C000039, 32'hFC0007FF, K_OTHER},
		'{32'h70000000, 32'hFC000000, K_OTHER}, '{32'h74000000, 32'hFC000000, K_OTHER},
		'{32'h7C000378, 32'hFC0007FE, K_OTHER}, '{32'h7C000379, 32'hFC0007FF, K_OTHER},
		'{32'h60000000, 32'hFC000000, K_OTHER}, '{32'h64000000, 32'hFC000000, K_OTHER},
		'{32'h7C000278, 32'hFC0007FE, K_OTHER}, '{32'h68000000, 32'hFC000000, K_OTHER},
		'{32'h6C000000, 32'hFC000000, K_OTHER},
		'{32'h48000000, 32'hFC000003, K_BREL},  '{32'h48000002, 32'hFC000003, K_BABS},
		'{32'h48000001, 32'hFC000003, K_BREL},  '{32'h40000000, 32'hFC000003, K_BCOND},
		'{32'h4C000020, 32'hFC00FFFE, K_BIND},  '{32'h4C000420, 32'hFC00FFFE, K_BIND},
		'{32'h4E800020, 32'hFFFFFFFF, K_BIND},  '{32'h4E800420, 32'hFFFFFFFF, K_BIND},
		'{32'h80000000, 32'hFC000000, K_LOAD},  '{32'h84000000, 32'hFC000000, K_LOAD},
		'{32'h7C00002E, 32'hFC0007FE, K_LOAD},  '{32'h90000000, 32'hFC000000, K_STORE},
		'{32'h94000000, 32'hFC000000, K_STORE}, '{32'h7C00012E, 32'hFC0007FE, K_STORE},
		'{32'h88000000, 32'hFC000000, K_LOAD},  '{32'h7C0000AE, 32'hFC0007FE, K_LOAD},
		'{32'h98000000, 32'hFC000000, K_STORE}, '{32'h7C0001AE, 32'hFC0007FE, K_STORE},
		'{32'hA0000000, 32'hFC000000, K_LOAD},  '{32'h7C00022E, 32'hFC0007FE, K_LOAD},
		'{32'hB0000000, 32'hFC000000, K_STORE}, '{32'h7C00032E, 32'hFC0007FE, K_STORE},
		'{32'hFC00002A, 32'hFC0007FE, K_OTHER}, '{32'hEC00002A, 32'hFC0007FE, K_OTHER},
		'{32'hFC000028, 32'hFC0007FE, K_OTHER}, '{32'hEC000028, 32'hFC0007FE, K_OTHER},
		'{32'hFC000032, 32'hFC0007FE, K_OTHER}, '{32'hEC000032, 32'hFC0007FE, K_OTHER},
		'{32'hFC000024, 32'hFC0007FE, K_OTHER}, '{32'hEC000024, 32'hFC0007FE, K_OTHER},
		'{32'hFC00003A, 32'hFC0007FE, K_OTHER}, '{32'hEC00003A, 32'hFC0007FE, K_OTHER},
		'{32'hC0000000, 32'hFC000000, K_LOAD},  '{32'hC8000000, 32'hFC000000, K_LOAD},
		'{32'hD0000000, 32'hFC000000, K_STORE}, '{32'hD8000000, 32'hFC000000, K_STORE},
		'{32'h1000002A, 32'hFC0007FE, K_OTHER}, '{32'h10000028, 32'hFC0007FE, K_OTHER},
		'{32'h10000032, 32'hFC0007FE, K_OTHER}, '{32'h10000024, 32'hFC0007FE, K_OTHER},
		'{32'h1000003A, 32'hFC0007FE, K_OTHER}, '{32'h10000420, 32'hFC0007FE, K_OTHER},
		'{32'h10000460, 32'hFC0007FE, K_OTHER}, '{32'h100004A0, 32'hFC0007FE, K_OTHER},
		'{32'h100004E0, 32'hFC0007FE, K_OTHER},
		'{32'hE0000000, 32'hFC000000, K_LOAD},  '{32'hF0000000, 32'hFC000000, K_STORE},
		'{32'h7C0802A6, 32'hFC1FFFFF, K_OTHER}, '{32'h7C0803A6, 32'hFC1FFFFF, K_OTHER},
		'{32'h7C0902A6, 32'hFC1FFFFF, K_OTHER}, '{32'h7C0903A6, 32'hFC1FFFFF, K_OTHER},
		'{32'h7C000026, 32'hFC1FFFFF, K_OTHER}, '{32'h7C000120, 32'hFC100FFF, K_OTHER},
		'{32'h4C00012C, 32'hFFFFFFFF, K_OTHER}, '{32'h7C0004AC, 32'hFFFFFFFF, K_OTHER},
		'{32'h7C000000, 32'hFC400000, K_OTHER}, '{32'h2C000000, 32'hFC400000, K_OTHER},
		'{32'h7C000040, 32'hFC400000, K_OTHER}, '{32'h28000000, 32'hFC400000, K_OTHER},
		'{32'h38000000, 32'hFFE00000, K_OTHER}, '{32'h3C000000, 32'hFFE00000, K_OTHER},
		'{32'h7C000378, 32'hFC0007FE, K_OTHER}, '{32'h60000000, 32'hFFFFFFFF, K_OTHER}
	};

endpackage

// File: src/ppd_match.sv
// Stage one: compares the word against every table row in parallel.
`timescale 1ns / 1ps

module ppd_match import ppd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  stage_ctl_t          ctl,
	input  logic [31:0]         instr_word,
	input  logic [31:0]         pc,
	output logic                valid_s1,
	output logic [NUM_ROWS-1:0] hit_s1,
	output logic [31:0]         word_s1,
	output logic [31:0]         pc_s1
);

	logic [NUM_ROWS-1:0] hit;

	// One masked compare per row.
	always_comb begin
		for (int i = 0; i < NUM_ROWS; i++) begin
			hit[i] = ((instr_word & ROWS[i].mask) == ROWS[i].value);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctl.load) begin
			valid_s1 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			hit_s1  <= hit;
			word_s1 <= instr_word;
			pc_s1   <= pc;
		end
	end

endmodule

// File: src/ppd_group.sv
// Stage two: finds the first hit inside each group of eight rows.
`timescale 1ns / 1ps

module ppd_group import ppd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  stage_ctl_t          ctl,
	input  logic [NUM_ROWS-1:0] hit,
	input  logic [31:0]         word,
	input  logic [31:0]         pc,
	output logic                valid_s2,
	output logic [NUM_GROUPS-1:0] any_s2,
	output logic [LOCAL_W-1:0]  local_s2 [NUM_GROUPS],
	output logic [31:0]         word_s2,
	output logic [31:0]         pc_s2
);

	logic [NUM_GROUPS-1:0] any;
	logic [LOCAL_W-1:0]    loc [NUM_GROUPS];

	// Per-group priority encode; lower row numbers win.
	always_comb begin
		for (int g = 0; g < NUM_GROUPS; g++) begin
			any[g] = 1'b0;
			loc[g] = '0;
			for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
				if (hit[g * GROUP_SIZE + j]) begin
					any[g] = 1'b1;
					loc[g] = LOCAL_W'(j);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ctl.load) begin
			valid_s2 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			any_s2   <= any;
			local_s2 <= loc;
			word_s2  <= word;
			pc_s2    <= pc;
		end
	end

endmodule

// File: src/ppd_select.sv
// Stage three: picks the first group with a hit and looks up the row kind.
`timescale 1ns / 1ps

module ppd_select import ppd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  stage_ctl_t            ctl,
	input  logic [NUM_GROUPS-1:0] any,
	input  logic [LOCAL_W-1:0]    loc [NUM_GROUPS],
	input  logic [31:0]           word,
	input  logic [31:0]           pc,
	output logic                  valid_s3,
	output logic                  hit_s3,
	output logic [IDX_W-1:0]      index_s3,
	output kind_t                 kind_s3,
	output logic [31:0]           word_s3,
	output logic [31:0]           pc_s3
);

	logic             hit;
	logic [IDX_W-1:0] index;
	kind_t            kind;

	// Lowest group with a hit wins; the row index is group base plus offset.
	always_comb begin
		hit   = 1'b0;
		index = '0;
		for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
			if (any[g]) begin
				hit   = 1'b1;
				index = IDX_W'(g * GROUP_SIZE) + IDX_W'(loc[g]);
			end
		end
		kind = hit ? ROWS[index].kind : K_OTHER;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ctl.load) begin
			valid_s3 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			hit_s3   <= hit;
			index_s3 <= index;
			kind_s3  <= kind;
			word_s3  <= word;
			pc_s3    <= pc;
		end
	end

endmodule

// File: src/ppd_extract.sv
// Stage four: extracts operand fields, sets flags and forms the branch target.
`timescale 1ns / 1ps

module ppd_extract import ppd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  stage_ctl_t         ctl,
	input  logic               hit,
	input  logic [IDX_W-1:0]   index,
	input  kind_t              kind,
	input  logic [31:0]        word,
	input  logic [31:0]        pc,
	output logic               valid_s4,
	output logic               hit_s4,
	output logic [IDX_W-1:0]   index_s4,
	output logic signed [25:0] a_s4,
	output logic signed [15:0] b_s4,
	output logic signed [15:0] c_s4,
	output logic [4:0]         d_s4,
	output logic               branch_s4,
	output logic               load_s4,
	output logic               store_s4,
	output logic [31:0]        target_s4
);

	logic [25:0] a;
	logic [15:0] b;
	logic [15:0] c;
	logic [4:0]  d;
	logic [31:0] target;
	logic        d_form;

	// Primary opcodes 32 through 47 use the load/store D-form.
	assign d_form = (word[31:30] == 2'b10);

	// Operand formats by row kind.
	always_comb begin
		a = '0;
		b = '0;
		c = '0;
		d = '0;
		if (hit) begin
			if (kind == K_BREL || kind == K_BABS) begin
				a = {word[25:2], 2'b00};
			end else if (kind == K_BCOND) begin
				a = {21'd0, word[25:21]};
				b = {11'd0, word[20:16]};
				c = {word[15:2], 2'b00};
			end else if (d_form) begin
				a = {21'd0, word[25:21]};
				b = word[15:0];
				c = {11'd0, word[20:16]};
			end else begin
				a = {21'd0, word[25:21]};
				b = {11'd0, word[20:16]};
				c = {11'd0, word[15:11]};
				d = word[10:6];
			end
		end
	end

	// Branch target: absolute, relative on the long or the short displacement.
	always_comb begin
		case (kind)
			K_BABS:  target = {{6{a[25]}}, a};
			K_BREL:  target = pc + {{6{a[25]}}, a};
			K_BCOND: target = pc + {{16{c[15]}}, c};
			default: target = '0;
		endcase
		if (!hit) begin
			target = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ctl.load) begin
			valid_s4 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			hit_s4    <= hit;
			index_s4  <= hit ? index : '0;
			a_s4      <= a;
			b_s4      <= b;
			c_s4      <= c;
			d_s4      <= d;
			branch_s4 <= hit && (kind == K_BREL || kind == K_BABS ||
			                     kind == K_BCOND || kind == K_BIND);
			load_s4   <= hit && (kind == K_LOAD);
			store_s4  <= hit && (kind == K_STORE);
			target_s4 <= target;
		end
	end

endmodule

// File: src/ppc_instruction_decoder.sv
// Top level of the four-stage PowerPC instruction decoder.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   instr_word, pc
//   out      source     out_valid / out_ready valid_res .. branch_target
//
// One word enters per cycle unless the full pipeline is stalled at the output.
// Words pass in order through row compare, group encode, group select with
// kind lookup, and field extraction with the target adder, each registered.
// Reset clears only the stage valid bits. A stall at the output holds each
// stage that is full, while empty stages further up keep filling.
`timescale 1ns / 1ps

module ppc_instruction_decoder import ppd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        instr_word,
	input  logic [31:0]        pc,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               valid_res,
	output logic [6:0]         entry_index,
	output logic signed [25:0] field_a,
	output logic signed [15:0] field_b,
	output logic signed [15:0] field_c,
	output logic [4:0]         field_d,
	output logic               is_branch,
	output logic               is_load,
	output logic               is_store,
	output logic [31:0]        branch_target
);

	stage_ctl_t ctl1, ctl2, ctl3, ctl4;

	logic                  valid_s1, valid_s2, valid_s3, valid_s4;
	logic [NUM_ROWS-1:0]   hit_s1;
	logic [31:0]           word_s1, word_s2, word_s3;
	logic [31:0]           pc_s1, pc_s2, pc_s3;
	logic [NUM_GROUPS-1:0] any_s2;
	logic [LOCAL_W-1:0]    local_s2 [NUM_GROUPS];
	logic                  hit_s3;
	logic [IDX_W-1:0]      index_s3;
	kind_t                 kind_s3;

	// A stage takes a word when it is empty or its own word moves on.
	assign ctl4.load  = !valid_s4 || out_ready;
	assign ctl3.load  = !valid_s3 || ctl4.load;
	assign ctl2.load  = !valid_s2 || ctl3.load;
	assign ctl1.load  = !valid_s1 || ctl2.load;
	assign ctl1.valid = in_valid;
	assign ctl2.valid = valid_s1;
	assign ctl3.valid = valid_s2;
	assign ctl4.valid = valid_s3;

	assign in_ready  = ctl1.load;
	assign out_valid = valid_s4;

	ppd_match u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl1),
		.instr_word (instr_word),
		.pc         (pc),
		.valid_s1   (valid_s1),
		.hit_s1     (hit_s1),
		.word_s1    (word_s1),
		.pc_s1      (pc_s1)
	);

	ppd_group u_group (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl2),
		.hit      (hit_s1),
		.word     (word_s1),
		.pc       (pc_s1),
		.valid_s2 (valid_s2),
		.any_s2   (any_s2),
		.local_s2 (local_s2),
		.word_s2  (word_s2),
		.pc_s2    (pc_s2)
	);

	ppd_select u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl3),
		.any      (any_s2),
		.loc      (local_s2),
		.word     (word_s2),
		.pc       (pc_s2),
		.valid_s3 (valid_s3),
		.hit_s3   (hit_s3),
		.index_s3 (index_s3),
		.kind_s3  (kind_s3),
		.word_s3  (word_s3),
		.pc_s3    (pc_s3)
	);

	ppd_extract u_extract (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl4),
		.hit       (hit_s3),
		.index     (index_s3),
		.kind      (kind_s3),
		.word      (word_s3),
		.pc        (pc_s3),
		.valid_s4  (valid_s4),
		.hit_s4    (valid_res),
		.index_s4  (entry_index),
		.a_s4      (field_a),
		.b_s4      (field_b),
		.c_s4      (field_c),
		.d_s4      (field_d),
		.branch_s4 (is_branch),
		.load_s4   (is_load),
		.store_s4  (is_store),
		.target_s4 (branch_target)
	);

`ifndef NO_ASSERTIONS
	// An accepted word always lands in the first stage.
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted word did not reach stage one");

	// With every stage full and the output stalled, no new word is taken.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && valid_s3 && valid_s4 && !out_ready |-> !in_ready)
		else $error("word accepted into a full stalled pipeline");

	// A miss gives an all-zero result; the row index, target and class flags are checked.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |->
		entry_index == '0 && branch_target == '0 && !is_branch && !is_load && !is_store)
		else $error("miss result carries nonzero fields");

	// At most one of the class flags, and a hit row index stays inside the table.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({is_branch, is_load, is_store}) &&
		entry_index < 7'(NUM_ROWS))
		else $error("bad class flags or row index");
`endif

endmodule

// File: verif/tb.sv
// Testbench for the PowerPC instruction decoder, scored against a table-driven decode.
`timescale 1ns / 1ps

module tb;
	import ppd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 12;
	localparam int MAX_REPORTS = 10;

	// One decoded result, laid out as the output ports.
	typedef struct packed {
		logic        valid_res;
		logic [6:0]  entry_index;
		logic [25:0] field_a;
		logic [15:0] field_b;
		logic [15:0] field_c;
		logic [4:0]  field_d;
		logic        is_branch;
		logic        is_load;
		logic        is_store;
		logic [31:0] branch_target;
	} decode_t;

	typedef struct {
		logic [31:0] word;
		decode_t     dec;
	} pending_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [31:0]        instr_word = '0;
	logic [31:0]        pc = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               valid_res;
	logic [6:0]         entry_index;
	logic signed [25:0] field_a;
	logic signed [15:0] field_b;
	logic signed [15:0] field_c;
	logic [4:0]         field_d;
	logic               is_branch;
	logic               is_load;
	logic               is_store;
	logic [31:0]        branch_target;

	pending_t pending_decodes[$];
	int       mismatch_cnt = 0;
	int       cycle_cnt = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	int       hold_len_req = 0;
	int       hold_left = 0;

	ppc_instruction_decoder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.instr_word    (instr_word),
		.pc            (pc),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.valid_res     (valid_res),
		.entry_index   (entry_index),
		.field_a       (field_a),
		.field_b       (field_b),
		.field_c       (field_c),
		.field_d       (field_d),
		.is_branch     (is_branch),
		.is_load       (is_load),
		.is_store      (is_store),
		.branch_target (branch_target)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("ppc_instruction_decoder test failed");
			$finish;
		end
	end

	// Decode one word: first matching table row, then its operand format and target.
	function automatic decode_t decode_word(logic [31:0] word, logic [31:0] addr);
		decode_t     r;
		int          hit;
		kind_t       k;
		logic [31:0] disp;
		r = '0;
		hit = -1;
		for (int i = 0; i < NUM_ROWS; i++) begin
			if (hit < 0 && (word & ROWS[i].mask) == ROWS[i].value)
				hit = i;
		end
		if (hit < 0)
			return r;
		k = ROWS[hit].kind;
		r.valid_res = 1'b1;
		r.entry_index = 7'(hit);
		disp = '0;
		if (k == K_BREL || k == K_BABS) begin
			disp = {{6{word[25]}}, word[25:2], 2'b00};
			r.field_a = disp[25:0];
		end else if (k == K_BCOND) begin
			disp = {{16{word[15]}}, word[15:2], 2'b00};
			r.field_a = {21'b0, word[25:21]};
			r.field_b = {11'b0, word[20:16]};
			r.field_c = disp[15:0];
		end else if (word[31:26] >= 6'd32 && word[31:26] <= 6'd47) begin
			r.field_a = {21'b0, word[25:21]};
			r.field_b = word[15:0];
			r.field_c = {11'b0, word[20:16]};
		end else begin
			r.field_a = {21'b0, word[25:21]};
			r.field_b = {11'b0, word[20:16]};
			r.field_c = {11'b0, word[15:11]};
			r.field_d = word[10:6];
		end
		case (k)
			K_BABS:  r.branch_target = disp;
			K_BREL:  r.branch_target = addr + disp;
			K_BCOND: r.branch_target = addr + disp;
			default: r.branch_target = '0;
		endcase
		r.is_branch = (k == K_BREL || k == K_BABS || k == K_BCOND || k == K_BIND);
		r.is_load = (k == K_LOAD);
		r.is_store = (k == K_STORE);
		return r;
	endfunction

	function automatic string fmt_decode(decode_t d);
		return $sformatf("v=%0d idx=%0d a=%07h b=%04h c=%04h d=%02h br/ld/st=%b%b%b tgt=%08h",
			d.valid_res, d.entry_index, d.field_a, d.field_b, d.field_c, d.field_d,
			d.is_branch, d.is_load, d.is_store, d.branch_target);
	endfunction

	// Word that hits a chosen table row most of the time, with random free bits.
	function automatic logic [31:0] random_word();
		int row;
		if ($urandom_range(99) < 80) begin
			row = $urandom_range(NUM_ROWS - 1);
			return (ROWS[row].value & ROWS[row].mask) | ($urandom & ~ROWS[row].mask);
		end
		return $urandom;
	endfunction

	function automatic logic [31:0] random_pc();
		case ($urandom_range(9))
			0:       return 32'($urandom_range(255));
			1:       return 32'hFFFF_FF00 | 32'($urandom_range(255));
			default: return $urandom;
		endcase
	endfunction

	// Offer one word, with random idle cycles first; returns at the accepting edge.
	task automatic send_word(logic [31:0] word, logic [31:0] addr);
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		instr_word <= word;
		pc <= addr;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = in_ready;
			if (taken)
				pending_decodes.push_back('{word, decode_word(word, addr)});
			@(posedge clk);
		end
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Output ready: a requested hold-off takes precedence over random stalls.
	always @(posedge clk) begin
		if (hold_len_req != 0) begin
			hold_left = hold_len_req;
			hold_len_req = 0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Score each word that leaves the block against the oldest prediction.
	always @(negedge clk) begin
		pending_t want;
		decode_t  got;
		if (arst_n && out_valid && out_ready) begin
			got = '{valid_res, entry_index, field_a, field_b, field_c, field_d,
				is_branch, is_load, is_store, branch_target};
			if (pending_decodes.size() == 0) begin
				if (mismatch_cnt < MAX_REPORTS)
					$display("unexpected result: %s", fmt_decode(got));
				mismatch_cnt++;
			end else begin
				want = pending_decodes.pop_front();
				if (got !== want.dec) begin
					if (mismatch_cnt < MAX_REPORTS) begin
						$display("mismatch for word %08h", want.word);
						$display("  expected %s", fmt_decode(want.dec));
						$display("  actual   %s", fmt_decode(got));
					end
					mismatch_cnt++;
				end
			end
		end
	end

	// Field extremes, every row kind, shadowed aliases and no-match words.
	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_word(32'h0000_0000, 32'h0000_0000);
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(32'h4BFF_FFFC, 32'h0000_0000);
		send_word(32'h49FF_FFFC, 32'hFFFF_FFF0);
		send_word(32'h4A00_0000, 32'h0000_0000);
		send_word(32'h4A00_0002, 32'h1234_5678);
		send_word(32'h49FF_FFFE, 32'h8765_4321);
		send_word(32'h4800_0001, 32'h7FFF_FFFC);
		send_word(32'h43FF_FFFC, 32'h0000_0004);
		send_word(32'h4000_7FFC, 32'hFFFF_FFFC);
		send_word(32'h4285_8000, 32'h0000_1000);
		send_word(32'h4E80_0020, $urandom);
		send_word(32'h4E80_0420, $urandom);
		send_word(32'h4C00_0021, $urandom);
		send_word(32'h83E0_8000, $urandom);
		send_word(32'h801F_FFFF, $urandom);
		send_word(32'hD3E0_FFF8, $urandom);
		send_word(32'hE3FF_FFFF, $urandom);
		send_word(32'h7C08_02A6, $urandom);
		send_word(32'h6000_0000, $urandom);
		send_word(32'h3800_0000, $urandom);
		send_word(32'h7C00_04AC, $urandom);
		send_word(32'h4C00_012C, $urandom);
		send_word(32'hFFFF_FFEB, $urandom);
		send_word(32'h13FF_FFAB, $urandom);
		go_idle();
	endtask

	task automatic test_random(int count, int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count)
			send_word(random_word(), random_pc());
		go_idle();
	endtask

	// Hold the output off long enough for the pipeline to fill and block the input.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_len_req = 150;
		repeat (60)
			send_word(random_word(), random_pc());
		go_idle();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_random(400, 0, 0);
		test_random(400, 67, 0);
		test_backpressure();
		test_random(400, 0, 67);
		test_random(290, 25, 25);
		while (pending_decodes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatch_cnt += pending_decodes.size();
		if (mismatch_cnt == 0)
			$display("ppc_instruction_decoder test passed");
		else
			$display("ppc_instruction_decoder test failed");
		$finish;
	end

endmodule

// File: sim.f
src/ppd_pkg.sv
src/ppd_match.sv
src/ppd_group.sv
src/ppd_select.sv
src/ppd_extract.sv
src/ppc_instruction_decoder.sv
verif/tb.sv
